// ===== sv/assert_macros.svh =====
// assertion macros shared by the queue rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue_core
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// operation codes on the kind field
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_PEEK   = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// move broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [15:0] key;
		logic signed [31:0] data;
	} cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// one slot of the sorted chain: holds one entry, trades with its neighbors
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                here_valid,
	input  logic                left_le,
	input  logic signed [15:0]  left_prio,
	input  logic signed [31:0]  left_data,
	input  logic signed [15:0]  right_prio,
	input  logic signed [31:0]  right_data,
	output logic                le,
	output logic signed [15:0]  prio,
	output logic signed [31:0]  data
);
	import spq_pkg::*;

	logic signed [15:0] prio_q;
	logic signed [31:0] data_q;

	// entry stays ahead of the new key when it is held and not larger
	assign le = here_valid && !(prio_q > ctrl.key);

	// per-cell move: keep, take the new entry, take from left or right
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (!le) begin
					if (left_le) begin
						prio_q <= ctrl.key;
						data_q <= ctrl.data;
					end else begin
						prio_q <= left_prio;
						data_q <= left_data;
					end
				end
			end
			CELL_SHIFT: begin
				prio_q <= right_prio;
				data_q <= right_data;
			end
			default: begin
			end
		endcase
	end

	assign prio = prio_q;
	assign data = data_q;

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// channel   | direction | fields
// in        | input     | kind, new_priority, new_data
// out       | output    | status, head_valid, head_priority, head_data, entry_count
//
// one transaction per cycle: every cell of the chain decides its move in parallel,
// so an insert, remove or peek completes in the cycle it is accepted.
// the result shows in the following cycle and is held until taken; the input is
// stalled only while an untaken result waits. reset empties the queue at once.
// top level of the sorted priority queue; depends on spq_pkg, spq_cell, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_priority_queue_core #(
	parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [15:0] new_priority,
	input  logic signed [31:0] new_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               head_valid,
	output logic signed [15:0] head_priority,
	output logic signed [31:0] head_data,
	output logic [4:0]         entry_count
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic          in_accept;
	logic          full;
	logic          empty;
	cell_ctrl_t    ctrl;
	logic [1:0]    status_d;

	logic               valid_w [DEPTH];
	logic               le_w    [DEPTH];
	logic signed [15:0] prio_w  [DEPTH];
	logic signed [31:0] data_w  [DEPTH];

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	// decode the transaction into a chain move and a status
	always_comb begin
		ctrl.op   = CELL_HOLD;
		ctrl.key  = new_priority;
		ctrl.data = new_data;
		status_d  = ST_DONE;
		case (kind)
			KIND_INSERT: begin
				if (full) status_d = ST_FULL;
				else if (in_accept) ctrl.op = CELL_INSERT;
			end
			KIND_REMOVE: begin
				if (empty) status_d = ST_EMPTY;
				else if (in_accept) ctrl.op = CELL_SHIFT;
			end
			KIND_PEEK: begin
				if (empty) status_d = ST_EMPTY;
			end
			default: begin
			end
		endcase
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign valid_w[i] = (CW'(i) < count_q);
		if (i == 0) begin : g_first
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.here_valid (valid_w[i]),
				.left_le    (1'b1),
				.left_prio  (new_priority),
				.left_data  (new_data),
				.right_prio (prio_w[i+1]),
				.right_data (data_w[i+1]),
				.le         (le_w[i]),
				.prio       (prio_w[i]),
				.data       (data_w[i])
			);
		end else if (i == DEPTH - 1) begin : g_last
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.here_valid (valid_w[i]),
				.left_le    (le_w[i-1]),
				.left_prio  (prio_w[i-1]),
				.left_data  (data_w[i-1]),
				.right_prio (prio_w[i]),
				.right_data (data_w[i]),
				.le         (le_w[i]),
				.prio       (prio_w[i]),
				.data       (data_w[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.here_valid (valid_w[i]),
				.left_le    (le_w[i-1]),
				.left_prio  (prio_w[i-1]),
				.left_data  (data_w[i-1]),
				.right_prio (prio_w[i+1]),
				.right_data (data_w[i+1]),
				.le         (le_w[i]),
				.prio       (prio_w[i]),
				.data       (data_w[i])
			);
		end
	end

	// fill count, status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
		end else begin
			if (in_accept) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
				if (ctrl.op == CELL_INSERT) count_q <= count_q + CW'(1);
				else if (ctrl.op == CELL_SHIFT) count_q <= count_q - CW'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result reads the state left by the last transaction
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign head_valid    = !empty;
	assign head_priority = empty ? 16'sd0 : prio_w[0];
	assign head_data     = empty ? 32'sd0 : data_w[0];
	assign entry_count   = 5'(count_q);

	// checks
	`SPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`SPQ_ASSERT_NEXT(a_insert_grows, clk, arst_n, in_accept && kind == KIND_INSERT && !full,
		count_q == $past(count_q) + CW'(1))
	`SPQ_ASSERT_NOW(a_full_status, clk, arst_n, out_valid_q && status_q == ST_FULL, full)
	`SPQ_ASSERT_NOW(a_empty_status, clk, arst_n, out_valid_q && status_q == ST_EMPTY, empty)

endmodule
